// ===== rtl/bcpe_pkg.sv =====
// Shared types, codes and helpers for the Bezier curve point evaluator.
package bcpe_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int COORD_W        = 32;
  localparam int T_W            = 17;
  localparam int PROD_W         = 51;

  localparam logic [T_W-1:0]    ONE_Q16    = 17'h10000;
  localparam logic [PROD_W-1:0] ROUND_HALF = 51'd32768;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  // x sits in the low bits
  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  function automatic logic [COORD_W-1:0] sat_sub(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    if (d[COORD_W] != d[COORD_W-1]) begin
      sat_sub = d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      sat_sub = d[COORD_W-1:0];
    end
  endfunction

  function automatic point_t point_sat_sub(input point_t a, input point_t b);
    point_t r;
    r.x = sat_sub(a.x, b.x);
    r.y = sat_sub(a.y, b.y);
    r.z = sat_sub(a.z, b.z);
    point_sat_sub = r;
  endfunction

endpackage

// ===== rtl/bcpe_lerp.sv =====
// One-coordinate interpolation unit: a + t*(b-a) with round half up.
module bcpe_lerp (
  input  logic                            clk,
  input  logic [bcpe_pkg::COORD_W-1:0]    a,
  input  logic [bcpe_pkg::COORD_W-1:0]    b,
  input  logic [bcpe_pkg::T_W-1:0]        t,
  output logic [bcpe_pkg::COORD_W-1:0]    res
);
  import bcpe_pkg::*;

  logic signed [COORD_W:0]   diff;
  logic signed [T_W:0]       t_s;
  logic signed [COORD_W-1:0] a_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  sum;

  assign diff = {b[COORD_W-1], b} - {a[COORD_W-1], a};
  assign t_s  = {1'b0, t};

  always_ff @(posedge clk) begin
    a_q    <= a;
    prod_q <= PROD_W'(t_s) * PROD_W'(diff);
  end

  // 65536*a + t*(b-a) + half, floor by 2^16
  assign sum = (PROD_W'(a_q) <<< 16) + prod_q + $signed(ROUND_HALF);
  assign res = sum[47:16];

endmodule

// ===== rtl/bezier_curve_point_eval.sv =====
// Bezier curve point evaluator: control point table and de Casteljau sequencer.
// Evaluate over n points: one pass per level, a pass of m outputs reads m+1 points and
// then drains through the read, interpolator register and write-back stages; the
// result becomes valid in the same cycle that the next request can be taken.
// Tangent mode stops at two points.
// One item in work at a time; reset clears control state and point_count to 2, not memories.
module bezier_curve_point_eval #(
  parameter int MAX_POINTS = bcpe_pkg::MAX_POINTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // point_index[4:0], coord_x[36:5], coord_y[68:37], coord_z[100:69],
  // param_t[117:101], want_tangent[118], zero pad[119]
  input  logic [119:0]  s_axis_tdata,
  // func[0]
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [95:0]   m_axis_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [5:0]    cfg_data
);
  import bcpe_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);

  state_t state, state_next;

  logic [5:0]    point_count;
  logic [4:0]    in_point_index;
  point_t        in_point;
  logic [T_W-1:0] in_param_t;
  logic          in_want_tangent;
  logic          in_accept;

  logic [NW-1:0] n_clamp;
  logic [T_W-1:0] t_clamp;
  logic [T_W-1:0] t_reg;
  logic          tangent_reg;
  logic          first_pass;
  logic          copy_pass;
  logic          last_pass;
  logic [NW-1:0] pass_m;
  logic [NW-1:0] rd_idx;
  logic [AW-1:0] rd_addr;

  logic          issue;
  logic          next_pass;
  logic          load_out;
  logic          start_eval;
  logic          ctrl_we;

  point_t        ctrl_mem [MAX_POINTS];
  point_t        work_mem [MAX_POINTS];
  point_t        rd_ctrl;
  point_t        rd_work;
  point_t        cur;
  point_t        prev;
  point_t        b_op;
  point_t        lerp_res;
  point_t        res0;
  point_t        res1;
  point_t        out_data;
  logic          out_valid;

  logic          s1_valid;
  logic [NW-1:0] s1_idx;
  logic          s2_valid;
  logic [NW-1:0] s2_idx;

  assign in_point_index  = s_axis_tdata[4:0];
  assign in_point.x      = s_axis_tdata[36:5];
  assign in_point.y      = s_axis_tdata[68:37];
  assign in_point.z      = s_axis_tdata[100:69];
  assign in_param_t      = s_axis_tdata[117:101];
  assign in_want_tangent = s_axis_tdata[118];

  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign start_eval = in_accept && (s_axis_tuser == FUNC_EVAL);
  assign ctrl_we    = in_accept && (s_axis_tuser == FUNC_WRITE) &&
                      (32'(in_point_index) < 32'(MAX_POINTS));

  assign cfg_ready = 1'b1;

  always_comb begin
    if (point_count < 6'd2) begin
      n_clamp = NW'(2);
    end else if (32'(point_count) > 32'(MAX_POINTS)) begin
      n_clamp = NW'(MAX_POINTS);
    end else begin
      n_clamp = NW'(point_count);
    end
  end

  assign t_clamp   = (in_param_t > ONE_Q16) ? ONE_Q16 : in_param_t;
  assign last_pass = (pass_m == (tangent_reg ? NW'(2) : NW'(1)));
  assign rd_addr   = rd_idx[AW-1:0];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    next_pass     = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && s_axis_tuser == FUNC_EVAL) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (rd_idx == pass_m) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last write-back before the next pass reads
        if (!s1_valid && !s2_valid) begin
          if (last_pass) begin
            state_next = ST_FINISH;
          end else begin
            next_pass  = 1'b1;
            state_next = ST_RUN;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 6'd2;
    end else if (cfg_valid && cfg_ready) begin
      point_count <= cfg_data;
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (start_eval) begin
      t_reg       <= t_clamp;
      tangent_reg <= in_want_tangent;
      first_pass  <= 1'b1;
      rd_idx      <= '0;
      // tangent over two points: one pass that just copies the table
      if (in_want_tangent && n_clamp == NW'(2)) begin
        copy_pass <= 1'b1;
        pass_m    <= NW'(2);
      end else begin
        copy_pass <= 1'b0;
        pass_m    <= n_clamp - NW'(1);
      end
    end else if (next_pass) begin
      first_pass <= 1'b0;
      copy_pass  <= 1'b0;
      pass_m     <= pass_m - NW'(1);
      rd_idx     <= '0;
    end else if (issue) begin
      rd_idx <= rd_idx + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_we) begin
      ctrl_mem[AW'(in_point_index)] <= in_point;
    end
    rd_ctrl <= ctrl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      work_mem[s2_idx[AW-1:0]] <= lerp_res;
    end
    rd_work <= work_mem[rd_addr];
  end

  assign cur  = first_pass ? rd_ctrl : rd_work;
  assign b_op = copy_pass ? prev : cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid && (s1_idx != '0);
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= rd_idx;
    s2_idx <= s1_idx - NW'(1);
    if (s1_valid) begin
      prev <= cur;
    end
    if (s2_valid && last_pass) begin
      if (s2_idx == NW'(0)) begin
        res0 <= lerp_res;
      end
      if (s2_idx == NW'(1)) begin
        res1 <= lerp_res;
      end
    end
  end

  bcpe_lerp u_lerp_x (.clk(clk), .a(prev.x), .b(b_op.x), .t(t_reg), .res(lerp_res.x));
  bcpe_lerp u_lerp_y (.clk(clk), .a(prev.y), .b(b_op.y), .t(t_reg), .res(lerp_res.y));
  bcpe_lerp u_lerp_z (.clk(clk), .a(prev.z), .b(b_op.z), .t(t_reg), .res(lerp_res.z));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= tangent_reg ? point_sat_sub(res0, res1) : res0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (!s1_valid && !s2_valid))
    else $error("request taken while interpolation pipeline busy");

  a_write_in_pass: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_idx < pass_m))
    else $error("write-back index beyond pass length");

  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> last_pass)
    else $error("result stage reached before final pass");

endmodule

// ===== bench/bezier_curve_point_eval_test.sv =====
// Self-checking stream testbench for the Bezier curve point evaluator.
module bezier_curve_point_eval_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bcpe_pkg::*;

  localparam int     NPTS        = MAX_POINTS_DEF;
  localparam int     RAND_ITEMS  = 1150;
  localparam int     HOLD_CYCLES = 3000;
  // the limit covers the worst case at 32 points with the longest gaps on both
  // sides, plus the hold-offs and settles, taken about 4x over
  localparam longint CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic        func;
    logic [4:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [16:0] t;
    logic        tangent;
  } req_t;

  typedef struct packed {
    req_t   req;
    logic   fixed;
    point_t want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // point_index, coord_x, coord_y, coord_z, param_t, want_tangent, zero pad
  logic [119:0] s_axis_tdata = '0;
  // func
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // out_x, out_y, out_z
  logic [95:0]  m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [5:0]   cfg_data = '0;

  bezier_curve_point_eval u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the control point table and the count register
  logic [31:0] tab_x [NPTS];
  logic [31:0] tab_y [NPTS];
  logic [31:0] tab_z [NPTS];
  bit          written [NPTS];
  logic [5:0]  count_reg = 6'd2;

  point_t curve_points[$];

  longint cycles;
  int     errors;
  int     results_seen;
  int     n_writes, n_evals, n_tangents, n_settings;
  int     holds_done;
  int     next_hold = 150;
  int     hold_left;
  int     sink_gap;
  bit     sink_steady;
  bit     src_steady;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, curve_points.size());
      $display("** bezier_curve_point_eval: FAILED **");
      $finish;
    end
  end

  task automatic flag(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR cycle %0d: %s", cycles, msg);
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic int eff_points(input logic [5:0] c);
    if (c < 2) return 2;
    if (c > NPTS) return NPTS;
    return c;
  endfunction

  // round half up of ((1 - t) * a + t * b) in Q16
  function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                        input logic [16:0] t);
    longint sa, sb, tt, acc;
    sa = $signed(a);
    sb = $signed(b);
    tt = t;
    acc = (65536 - tt) * sa + tt * sb + 32768;
    acc = acc >>> 16;
    return acc[31:0];
  endfunction

  function automatic logic [31:0] clamp_diff(input logic [31:0] a, input logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    return d[31:0];
  endfunction

  function automatic point_t eval_curve(input logic [16:0] t_in, input logic tangent);
    logic [31:0] wx [NPTS];
    logic [31:0] wy [NPTS];
    logic [31:0] wz [NPTS];
    logic [16:0] t;
    point_t      p;
    int          n;
    t = (t_in > ONE_Q16) ? ONE_Q16 : t_in;
    n = eff_points(count_reg);
    for (int i = 0; i < n; i++) begin
      wx[i] = tab_x[i];
      wy[i] = tab_y[i];
      wz[i] = tab_z[i];
    end
    for (int lvl = 1; lvl < n; lvl++) begin
      // tangent stops with two intermediates left
      if (tangent && n - lvl + 1 == 2) break;
      for (int i = 0; i + lvl < n; i++) begin
        wx[i] = blend(wx[i], wx[i+1], t);
        wy[i] = blend(wy[i], wy[i+1], t);
        wz[i] = blend(wz[i], wz[i+1], t);
      end
    end
    if (tangent) begin
      p.x = clamp_diff(wx[0], wx[1]);
      p.y = clamp_diff(wy[0], wy[1]);
      p.z = clamp_diff(wz[0], wz[1]);
    end else begin
      p.x = wx[0];
      p.y = wy[0];
      p.z = wz[0];
    end
    return p;
  endfunction

  // update the mirror for an accepted request and queue its result
  task automatic apply_request(input row_t r);
    if (r.req.func == FUNC_WRITE) begin
      tab_x[r.req.idx] = r.req.x;
      tab_y[r.req.idx] = r.req.y;
      tab_z[r.req.idx] = r.req.z;
      written[r.req.idx] = 1'b1;
      n_writes++;
    end else begin
      n_evals++;
      if (r.req.tangent) n_tangents++;
      curve_points.insert(curve_points.size(),
                          r.fixed ? r.want : eval_curve(r.req.t, r.req.tangent));
    end
  endtask

  task automatic offer(input row_t r);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.req.func;
    s_axis_tdata  <= {1'b0, r.req.tangent, r.req.t, r.req.z, r.req.y, r.req.x, r.req.idx};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    apply_request(r);
  endtask

  task automatic pause_source(input int n);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (!src_steady && $urandom_range(0, 99) < 30) pause_source(gap_len());
  endtask

  // stop offering, wait for every pending result, then let a write finish
  task automatic settle(input int tail);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (curve_points.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_count(input logic [5:0] v);
    settle(8);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    count_reg = v;
    n_settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic row_t wr_row(input logic [4:0] idx, input logic [31:0] x,
                                  input logic [31:0] y, input logic [31:0] z);
    row_t r;
    r = '0;
    r.req.func    = FUNC_WRITE;
    r.req.idx     = idx;
    r.req.x       = x;
    r.req.y       = y;
    r.req.z       = z;
    r.req.t       = 17'($urandom_range(0, 131071));
    r.req.tangent = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic row_t ev_row(input logic [16:0] t, input logic tangent, input logic fixed,
                                  input logic [31:0] ex, input logic [31:0] ey,
                                  input logic [31:0] ez);
    row_t r;
    r.req.func    = FUNC_EVAL;
    r.req.idx     = 5'($urandom);
    r.req.x       = $urandom;
    r.req.y       = $urandom;
    r.req.z       = $urandom;
    r.req.t       = t;
    r.req.tangent = tangent;
    r.fixed       = fixed;
    r.want.x      = ex;
    r.want.y      = ey;
    r.want.z      = ez;
    return r;
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] pick_param();
    case ($urandom_range(0, 9))
      0:       return 17'd0;
      1:       return ONE_Q16;
      2:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // evaluate only once every slot in use has been written; else fill the first hole
  function automatic row_t random_row();
    row_t r;
    int   n, hole;
    n = eff_points(count_reg);
    hole = -1;
    for (int i = n - 1; i >= 0; i--) if (!written[i]) hole = i;
    if (hole < 0 && $urandom_range(0, 99) < 60) begin
      r = ev_row(pick_param(), $urandom_range(0, 99) < 40, 1'b0, '0, '0, '0);
    end else begin
      if (hole < 0) hole = ($urandom_range(0, 4) != 0) ? $urandom_range(0, n - 1)
                                                      : $urandom_range(0, NPTS - 1);
      r = wr_row(5'(hole), pick_coord(), pick_coord(), pick_coord());
    end
    return r;
  endfunction

  // output side: random backpressure, quiet stretches, and two long hold-offs
  always @(negedge clk) begin
    logic ready_n;
    if (results_seen >= next_hold && holds_done < 2) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
      next_hold += 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_n = 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      ready_n = 1'b0;
    end else if (!sink_steady && $urandom_range(0, 99) < 25) begin
      sink_gap = gap_len() - 1;
      ready_n = 1'b0;
    end else begin
      ready_n = 1'b1;
    end
    if ($urandom_range(0, 299) == 0) sink_steady = !sink_steady;
    m_axis_tready <= ready_n;
  end

  always @(posedge clk) begin
    point_t want, seen;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      results_seen++;
      seen = m_axis_tdata;
      if (curve_points.size() == 0) begin
        flag($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        want = curve_points.pop_front();
        if (seen.x !== want.x)
          flag($sformatf("result %0d x: expected %h, got %h", results_seen, want.x, seen.x));
        if (seen.y !== want.y)
          flag($sformatf("result %0d y: expected %h, got %h", results_seen, want.y, seen.y));
        if (seen.z !== want.z)
          flag($sformatf("result %0d z: expected %h, got %h", results_seen, want.z, seen.z));
      end
    end
  end

  initial begin
    row_t       dir_tab [];
    logic [5:0] plan [$];
    logic [5:0] cv;
    int         n_rand, phase, len, pick;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // point_count is 2 after reset
    dir_tab = {
      wr_row(5'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000),
      wr_row(5'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000),
      ev_row(17'd0,      1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000),
      ev_row(17'd65536,  1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000),
      ev_row(17'd131071, 1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000),
      ev_row(17'd65537,  1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000),
      // two points in tangent mode: plain saturated difference, t unused
      ev_row(17'd0,      1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000),
      ev_row(17'd131071, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000),
      ev_row(17'h08000,  1'b0, 1'b0, '0, '0, '0),
      ev_row(17'd1,      1'b0, 1'b0, '0, '0, '0),
      ev_row(17'd65535,  1'b0, 1'b0, '0, '0, '0),
      wr_row(5'd0, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000),
      wr_row(5'd1, 32'h0001_0000, 32'h0000_0000, 32'h0000_0001),
      // exact halves round up
      ev_row(17'h08000,  1'b0, 1'b1, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001),
      ev_row(17'h08000,  1'b1, 1'b1, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_FFFF),
      wr_row(5'd31, 32'h1234_5678, 32'h9ABC_DEF0, 32'hFFFF_FFFF)
    };
    foreach (dir_tab[i]) begin
      offer(dir_tab[i]);
      maybe_gap();
    end

    // count extremes first, including the clamped ones
    plan = {6'd3, 6'd0, 6'd1, 6'd5, 6'd32, 6'd63, 6'd33, 6'd2};
    phase = 0;
    while (n_rand < RAND_ITEMS) begin
      if (plan.size() != 0) begin
        cv = plan.pop_front();
      end else begin
        pick = $urandom_range(0, 99);
        cv = (pick < 75) ? 6'($urandom_range(2, 8)) :
             (pick < 93) ? 6'($urandom_range(9, 31)) : 6'($urandom_range(32, 63));
      end
      set_count(cv);
      len = (eff_points(cv) > 12) ? $urandom_range(8, 16) : $urandom_range(30, 50);
      src_steady = (phase % 3 == 2);
      for (int k = 0; k < len && n_rand < RAND_ITEMS; k++) begin
        offer(random_row());
        n_rand++;
        if (k == len / 2 && phase % 4 == 1) settle(8);
        else maybe_gap();
      end
      phase++;
    end

    settle(700);
    $display("Ran %0d writes and %0d evaluations (%0d tangent) over %0d point_count settings,",
             n_writes, n_evals, n_tangents, n_settings);
    $display("counts 0, 1, 2, 32, 33 and 63 included; %0d results checked, %0d long hold-offs.",
             results_seen, holds_done);
    if (errors == 0) begin
      $display("** bezier_curve_point_eval: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** bezier_curve_point_eval: FAILED **");
    end
    $finish;
  end

endmodule

// ===== bezier_curve_point_eval.f =====
rtl/bcpe_pkg.sv
rtl/bcpe_lerp.sv
rtl/bezier_curve_point_eval.sv
bench/bezier_curve_point_eval_test.sv
